>>> src/tvbf_pkg.sv
// tvbf_pkg: shared constants, types and character codes for the text view byte filter
// used by every module of the filter; depends on nothing

package tvbf_pkg;

   // line counter: BCD digits
   localparam int LINE_DIGITS = 10;
   localparam int CNT_W       = 4 * LINE_DIGITS;
   localparam int DIG_IDX_W   = $clog2(LINE_DIGITS);
   localparam int SIG_W       = $clog2(LINE_DIGITS + 1);

   // run layout
   localparam int NUM_PAD     = 6;
   localparam int MAX_RUN     = 15;
   localparam int TAIL_MAX    = 4;
   localparam int TAIL_IDX_W  = $clog2(TAIL_MAX);
   localparam int TAIL_LEN_W  = $clog2(TAIL_MAX + 1);
   localparam int NUM_LEN_MAX = ((LINE_DIGITS > NUM_PAD) ? LINE_DIGITS : NUM_PAD) + 1;
   localparam int POS_W       = $clog2(NUM_LEN_MAX + TAIL_MAX + 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_NUMBER_NONBLANK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUMBER_ALL       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SQUEEZE_BLANK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_ENDS        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_TABS        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SHOW_NONPRINTING = 3'd5;

   // character codes
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_DOLLAR = 8'd36;
   localparam logic [7:0] CH_DASH   = 8'd45;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_QMARK  = 8'd63;
   localparam logic [7:0] CH_I      = 8'd73;
   localparam logic [7:0] CH_M      = 8'd77;
   localparam logic [7:0] CH_CARET  = 8'd94;
   localparam logic [7:0] CH_DEL    = 8'd127;
   localparam logic [7:0] OFS_CTRL  = 8'd64;
   localparam logic [7:0] OFS_HIGH  = 8'd128;
   localparam logic [7:0] HIGH_CTRL_END = 8'd160;
   localparam logic [7:0] CTRL_END  = 8'd32;

   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic squeeze_blank;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
   } cfg_type;

   // one classified word: line number snapshot and the bytes after it
   typedef struct packed {
      logic [CNT_W-1:0]               count;
      logic [POS_W-1:0]               pad_len;
      logic [POS_W-1:0]               num_len;
      logic [POS_W-1:0]               run_last;
      logic [TAIL_MAX-1:0][7:0]       tail;
   } entry_type;

endpackage

>>> src/tvbf_front.sv
// tvbf_front: accepts input words, classifies them and keeps the line state
// depends on tvbf_pkg

module tvbf_front import tvbf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      in_valid,
   output logic      in_ready,
   input  logic [7:0] in_byte,
   input  logic      queue_full,
   output logic      push,
   output entry_type push_entry
);

   logic             prev_nl_ff, prev_nl_in;
   logic             blank_ff, blank_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             accept;
   logic             is_nl;
   logic             squeezed;
   logic             numbered;
   logic [3:0]       digits [LINE_DIGITS];
   logic [SIG_W-1:0] sig;
   logic [TAIL_MAX-1:0][7:0] tail;
   logic [TAIL_LEN_W-1:0]    tail_len;
   logic [POS_W-1:0] num_w;
   logic [POS_W-1:0] num_len;
   logic [POS_W-1:0] total;
   logic [POS_W-1:0] capped;
   logic [LINE_DIGITS:0] carry;
   logic             all_nines;

   // handshake
   assign in_ready = !queue_full && !reset;
   assign accept   = in_valid && in_ready;

   // classification
   assign is_nl    = (in_byte == CH_NL);
   assign squeezed = cfg.squeeze_blank && blank_ff && is_nl;
   assign numbered = prev_nl_ff &&
                     (cfg.number_nonblank ? !is_nl : (cfg.number_all && !squeezed));

   // digit view and significant digit count
   always_comb begin
      sig = SIG_W'(1);
      for (int i = 0; i < LINE_DIGITS; i++) begin
         digits[i] = count_ff[4*i +: 4];
         if (count_ff[4*i +: 4] != 4'd0) begin
            sig = SIG_W'(i + 1);
         end
      end
   end

   // bytes that follow the line number
   always_comb begin
      tail     = '0;
      tail_len = '0;
      if (squeezed) begin
         tail_len = '0;
      end else if (cfg.show_tabs && in_byte == CH_TAB) begin
         tail[0]  = CH_CARET;
         tail[1]  = CH_I;
         tail_len = TAIL_LEN_W'(2);
      end else if (cfg.show_nonprinting && in_byte != CH_TAB && !is_nl) begin
         if (in_byte >= HIGH_CTRL_END) begin
            tail[0]  = CH_M;
            tail[1]  = CH_DASH;
            tail[2]  = in_byte - OFS_HIGH;
            tail_len = TAIL_LEN_W'(3);
         end else if (in_byte >= OFS_HIGH) begin
            tail[0]  = CH_M;
            tail[1]  = CH_DASH;
            tail[2]  = CH_CARET;
            tail[3]  = in_byte - OFS_CTRL;
            tail_len = TAIL_LEN_W'(4);
         end else if (in_byte < CTRL_END) begin
            tail[0]  = CH_CARET;
            tail[1]  = in_byte + OFS_CTRL;
            tail_len = TAIL_LEN_W'(2);
         end else if (in_byte == CH_DEL) begin
            tail[0]  = CH_CARET;
            tail[1]  = CH_QMARK;
            tail_len = TAIL_LEN_W'(2);
         end else begin
            tail[0]  = in_byte;
            tail_len = TAIL_LEN_W'(1);
         end
      end else if (cfg.show_ends && is_nl) begin
         tail[0]  = CH_DOLLAR;
         tail[1]  = CH_NL;
         tail_len = TAIL_LEN_W'(2);
      end else begin
         tail[0]  = in_byte;
         tail_len = TAIL_LEN_W'(1);
      end
   end

   // run length, capped at the longest run
   always_comb begin
      num_w   = (POS_W'(sig) > POS_W'(NUM_PAD)) ? POS_W'(sig) : POS_W'(NUM_PAD);
      num_len = numbered ? (num_w + POS_W'(1)) : '0;
      total   = num_len + POS_W'(tail_len);
      capped  = (total > POS_W'(MAX_RUN)) ? POS_W'(MAX_RUN) : total;
   end

   // queue word
   always_comb begin
      push                = accept && (numbered || tail_len != '0);
      push_entry.count    = count_ff;
      push_entry.pad_len  = num_w - POS_W'(sig);
      push_entry.num_len  = num_len;
      push_entry.run_last = capped - POS_W'(1);
      push_entry.tail     = tail;
   end

   // bcd increment, holds at all nines
   always_comb begin
      carry[0]  = 1'b1;
      all_nines = 1'b1;
      for (int i = 0; i < LINE_DIGITS; i++) begin
         carry[i+1] = carry[i] && (digits[i] == 4'd9);
         if (digits[i] != 4'd9) begin
            all_nines = 1'b0;
         end
      end
      count_in = count_ff;
      if (accept && numbered && !all_nines) begin
         for (int i = 0; i < LINE_DIGITS; i++) begin
            if (carry[i]) begin
               count_in[4*i +: 4] = (digits[i] == 4'd9) ? 4'd0 : (digits[i] + 4'd1);
            end
         end
      end
   end

   // line state
   always_comb begin
      prev_nl_in = prev_nl_ff;
      blank_in   = blank_ff;
      if (accept) begin
         prev_nl_in = is_nl;
         blank_in   = prev_nl_ff && is_nl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_nl_ff <= 1'b1;
         blank_ff   <= 1'b0;
         count_ff   <= CNT_W'(1);
      end else begin
         prev_nl_ff <= prev_nl_in;
         blank_ff   <= blank_in;
         count_ff   <= count_in;
      end
   end

endmodule

>>> src/tvbf_queue.sv
// tvbf_queue: short fifo of classified words between front and back
// depends on tvbf_pkg

module tvbf_queue import tvbf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry,
   output logic      full
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // pointers and fill count
   always_comb begin
      wr_ptr_in = push ? (wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? (rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> src/tvbf_back.sv
// tvbf_back: walks each queued word byte by byte into the output register
// depends on tvbf_pkg

module tvbf_back import tvbf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head_entry,
   output logic       pop,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic       out_last
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;

   logic             advance;
   logic             at_last;
   logic [3:0]       digits [LINE_DIGITS];
   logic [POS_W-1:0] dig_pos;
   logic [POS_W-1:0] tail_pos;
   logic [7:0]       cur_byte;

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

   assign advance = head_valid && (!valid_ff || out_ready);
   assign at_last = (pos_ff == head_entry.run_last);
   assign pop     = advance && at_last;

   // byte at the current position: pad, digits, tab, then the tail
   always_comb begin
      for (int i = 0; i < LINE_DIGITS; i++) begin
         digits[i] = head_entry.count[4*i +: 4];
      end
      dig_pos  = head_entry.num_len - POS_W'(2) - pos_ff;
      tail_pos = pos_ff - head_entry.num_len;
      if (pos_ff < head_entry.num_len) begin
         if (pos_ff < head_entry.pad_len) begin
            cur_byte = CH_SPACE;
         end else if (pos_ff == head_entry.num_len - POS_W'(1)) begin
            cur_byte = CH_TAB;
         end else begin
            cur_byte = CH_ZERO + {4'd0, digits[dig_pos[DIG_IDX_W-1:0]]};
         end
      end else begin
         cur_byte = head_entry.tail[tail_pos[TAIL_IDX_W-1:0]];
      end
   end

   // output register and run position
   always_comb begin
      pos_in   = pos_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = at_last;
         pos_in   = at_last ? '0 : (pos_ff + POS_W'(1));
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

>>> src/text_view_byte_filter_unit.sv
// text_view_byte_filter_unit: top level of the text view byte filter
// depends on tvbf_pkg, tvbf_front, tvbf_queue and tvbf_back

// Takes one text byte per req word and returns its display form as a run of
// rsp words, one byte each, with rsp_last_of_run set on the final byte of the
// run. Input bytes are taken at one per cycle while the four-deep queue between
// the classifier and the byte sequencer has room; the output side gives one
// byte per cycle while rsp_ready is high and a word is queued. A run has 1 to
// 15 bytes (a plain byte gives one, a numbered line start up to 11 more); a
// newline dropped by squeeze is taken with no output. The single output byte
// register sets the sustained rate. The first byte of a run passes through the
// queue and the output byte register. Registers are written through csr_we,
// csr_index and csr_wdata and should be changed only while the block is idle.

module text_view_byte_filter_unit import tvbf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      push;
   logic      pop;
   logic      full;
   logic      head_valid;
   entry_type push_entry;
   entry_type head_entry;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_wdata;
            CSR_NUMBER_ALL:       cfg_in.number_all       = csr_wdata;
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_wdata;
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_wdata;
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_wdata;
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classifier
   tvbf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_byte    (req_data_byte),
      .queue_full (full),
      .push       (push),
      .push_entry (push_entry)
   );

   // word queue
   tvbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (full)
   );

   // byte sequencer
   tvbf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_byte   (rsp_out_byte),
      .out_last   (rsp_last_of_run)
   );

endmodule

>>> src/tvbf_checker.sv
// tvbf_checker: port-level checks of the text view byte filter, bound to the top level
// depends on text_view_byte_filter_unit

module tvbf_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [7:0]           rsp_out_byte,
   input logic                 rsp_last_of_run
);

   // a stalled output word holds its bytes
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last_of_run))
      else $error("rsp word changed while stalled");

   // reset leaves no output pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a taken byte inside a run is followed at once by the next one
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid)
      else $error("gap inside a run");

   // input back-pressure only while output is pending
   a_stall_has_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with nothing on the output");

endmodule

bind text_view_byte_filter_unit tvbf_checker u_checker (.*);
